### design/ordered_list_engine_macros.svh
// assertion helpers for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define OLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ordered list engine check failed");

// next-cycle implication, sampled on aclk, off during reset
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ordered list engine check failed");

`endif

### design/olist_pkg.sv
`timescale 1ns / 1ps

package olist_pkg;

    localparam int OLIST_DEPTH = 16;
    localparam int VALUE_W     = 32;

    localparam logic [3:0] ACT_APPEND   = 4'd0;
    localparam logic [3:0] ACT_PUSH     = 4'd1;
    localparam logic [3:0] ACT_POP_HEAD = 4'd2;
    localparam logic [3:0] ACT_POP_TAIL = 4'd3;
    localparam logic [3:0] ACT_RMV_VAL  = 4'd4;
    localparam logic [3:0] ACT_RMV_IDX  = 4'd5;
    localparam logic [3:0] ACT_INSERT   = 4'd6;
    localparam logic [3:0] ACT_READ     = 4'd7;
    localparam logic [3:0] ACT_FIND     = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_USE   = 5'b00100,
        S_PLACE = 5'b01000,
        S_REPLY = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        OP_INS,
        OP_DEL,
        OP_FIND,
        OP_READ
    } op_t;

endpackage

### design/olist_ram.sv
`timescale 1ns / 1ps

module olist_ram import olist_pkg::*; #(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = OLIST_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/ordered_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values, held in one RAM and worked
// by a small sequencer around a single read port, write port and comparator.
// Each entry moved, or each entry examined by a search, takes a RAM read
// (S_FETCH) and then a write or compare (S_USE), so the time of a request
// follows the number of entries it touches; a refused request goes straight
// to the reply. One request is in work at a time; the next one is taken while
// the previous result still waits in the output register.
module ordered_list_engine import olist_pkg::*; #(
    parameter int DEPTH = OLIST_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // action [3:0], position [11:4], item_value [43:12], zero fill [47:44]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // status [1:0], read_value [33:2], found_index [41:34], entry_count [49:42],
    // zero fill [55:50]
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    `include "ordered_list_engine_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [3:0]         in_action;
    logic [7:0]         in_pos;
    logic [VALUE_W-1:0] in_val;

    assign in_action = s_axis_tdata[3:0];
    assign in_pos    = s_axis_tdata[11:4];
    assign in_val    = s_axis_tdata[43:12];

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic               grab_reg, grab_next;
    logic               rmv_reg, rmv_next;
    logic               first_reg, first_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [CW-1:0]      p_reg, p_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         status_reg, status_next;
    logic [VALUE_W-1:0] rval_reg, rval_next;
    logic [7:0]         fidx_reg, fidx_next;

    logic               m_valid_reg, m_valid_next;
    logic [55:0]        m_data_reg, m_data_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               accept;
    logic               full;
    logic               empty;
    logic               hit;
    logic [CW-1:0]      j_inc;
    logic [CW-1:0]      j_dec;
    logic [CW-1:0]      del_j;

    olist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CW'(DEPTH));
    assign empty         = (count_reg == '0);
    assign hit           = (ram_rdata == val_reg);
    assign j_inc         = j_reg + CW'(1);
    assign j_dec         = j_reg - CW'(1);
    assign del_j         = first_reg ? j_reg : j_inc;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        grab_next    = grab_reg;
        rmv_next     = rmv_reg;
        first_next   = first_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        rval_next    = rval_reg;
        fidx_next    = fidx_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = AW'(j_reg);
        ram_wdata    = ram_rdata;
        ram_raddr    = AW'(j_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    val_next    = in_val;
                    status_next = ST_OK;
                    rval_next   = '0;
                    fidx_next   = '0;
                    grab_next   = 1'b0;
                    rmv_next    = 1'b0;
                    first_next  = 1'b0;
                    state_next  = S_REPLY;
                    unique case (in_action)
                        ACT_APPEND, ACT_PUSH, ACT_INSERT: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                op_next = OP_INS;
                                j_next  = count_reg;
                                if (in_action == ACT_APPEND) begin
                                    p_next = count_reg;
                                end else if (in_action == ACT_PUSH) begin
                                    p_next = '0;
                                end else if (in_pos >= 8'(count_reg)) begin
                                    p_next = count_reg;
                                end else begin
                                    p_next = CW'(in_pos);
                                end
                                state_next = (j_next == p_next) ? S_PLACE : S_FETCH;
                            end
                        end
                        ACT_POP_HEAD, ACT_POP_TAIL: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                op_next    = OP_DEL;
                                grab_next  = 1'b1;
                                first_next = 1'b1;
                                j_next     = (in_action == ACT_POP_HEAD) ? '0
                                                                         : count_reg - CW'(1);
                                state_next = S_FETCH;
                            end
                        end
                        ACT_RMV_VAL, ACT_FIND: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                op_next    = OP_FIND;
                                rmv_next   = (in_action == ACT_RMV_VAL);
                                j_next     = '0;
                                state_next = S_FETCH;
                            end
                        end
                        ACT_RMV_IDX, ACT_READ: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                            end else if (in_pos >= 8'(count_reg)) begin
                                status_next = ST_MISS;
                            end else begin
                                op_next    = (in_action == ACT_READ) ? OP_READ : OP_DEL;
                                grab_next  = 1'b1;
                                first_next = 1'b1;
                                j_next     = CW'(in_pos);
                                state_next = S_FETCH;
                            end
                        end
                        default: begin
                            status_next = ST_MISS;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                unique case (op_reg)
                    OP_INS:  ram_raddr = AW'(j_dec);
                    OP_DEL:  ram_raddr = AW'(del_j);
                    default: ram_raddr = AW'(j_reg);
                endcase
                state_next = S_USE;
            end
            S_USE: begin
                unique case (op_reg)
                    OP_INS: begin
                        // move entry j-1 up into slot j
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(j_reg);
                        j_next     = j_dec;
                        state_next = (j_dec == p_reg) ? S_PLACE : S_FETCH;
                    end
                    OP_DEL: begin
                        if (first_reg) begin
                            if (grab_reg) begin
                                rval_next = ram_rdata;
                            end
                            first_next = 1'b0;
                        end else begin
                            // close the gap: entry j+1 down into slot j
                            ram_we    = 1'b1;
                            ram_waddr = AW'(j_reg);
                            j_next    = j_inc;
                        end
                        if (del_j + CW'(1) < count_reg) begin
                            state_next = S_FETCH;
                        end else begin
                            count_next = count_reg - CW'(1);
                            state_next = S_REPLY;
                        end
                    end
                    OP_FIND: begin
                        if (hit) begin
                            if (rmv_reg) begin
                                op_next    = OP_DEL;
                                first_next = 1'b0;
                                grab_next  = 1'b0;
                                if (j_inc < count_reg) begin
                                    state_next = S_FETCH;
                                end else begin
                                    count_next = count_reg - CW'(1);
                                    state_next = S_REPLY;
                                end
                            end else begin
                                fidx_next  = 8'(j_reg);
                                state_next = S_REPLY;
                            end
                        end else if (j_inc == count_reg) begin
                            status_next = ST_MISS;
                            state_next  = S_REPLY;
                        end else begin
                            j_next     = j_inc;
                            state_next = S_FETCH;
                        end
                    end
                    OP_READ: begin
                        rval_next  = ram_rdata;
                        state_next = S_REPLY;
                    end
                    default: begin
                        state_next = S_REPLY;
                    end
                endcase
            end
            S_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(p_reg);
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_REPLY;
            end
            S_REPLY: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, 8'(count_reg), fidx_reg, rval_reg, status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        grab_reg   <= grab_next;
        rmv_reg    <= rmv_next;
        first_reg  <= first_next;
        j_reg      <= j_next;
        p_reg      <= p_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rval_reg   <= rval_next;
        fidx_reg   <= fidx_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `OLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `OLE_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready)
    `OLE_ASSERT_NEXT(a_count_quiet, state_reg == S_IDLE, count_reg == $past(count_reg))

endmodule
